FILE: sv/assert_macros.svh
// assertion macros used by the timer table rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: sv/mct_pkg.sv
// types and constants of the countdown timer table
package mct_pkg;

  localparam int SLOT_COUNT = 8;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);

  localparam int COUNT_W = 16;
  localparam int TAG_W   = 8;
  localparam int SID_W   = 4;

  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_STOP  = 2'd1,
    FUNC_TICK  = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    KIND_STARTED      = 3'd0,
    KIND_FULL         = 3'd1,
    KIND_STOPPED      = 3'd2,
    KIND_STOP_IGNORED = 3'd3,
    KIND_EXPIRED      = 3'd4,
    KIND_NO_EXPIRY    = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_MOD,
    ST_END
  } state_e;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [COUNT_W-1:0] period;
    logic [TAG_W-1:0]   tag;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

FILE: sv/multi_slot_countdown_timer_table.sv
// countdown timer table: slot allocation, stop and tick walk over a ram
//
//   channel | valid      | stall       | payload
//   in      | in_valid_i | in_stall_o  | func_i count_ticks_i periodic_i handler_tag_i slot_id_i
//   out     | out_valid_o| out_stall_i | kind_o slot_o expired_tag_o last_o
//
// start and stop each give one result from the output register.
// a tick walks the slots from its accept cycle: each slot is read in ST_READ, an active
// slot then goes through ST_MOD (ram read then write back), and ST_END closes the walk;
// the single ram port pair makes the walk take the slots one at a time.
// reset clears the active flags and control state; ram contents are written before read.
// a stalled output holds the walk at the next expiry and blocks new transactions.
`include "assert_macros.svh"

module multi_slot_countdown_timer_table
  import mct_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         func_i,
  input  logic [COUNT_W-1:0] count_ticks_i,
  input  logic               periodic_i,
  input  logic [TAG_W-1:0]   handler_tag_i,
  input  logic [SID_W-1:0]   slot_id_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         kind_o,
  output logic [SID_W-1:0]   slot_o,
  output logic [TAG_W-1:0]   expired_tag_o,
  output logic               last_o
);

  state_e state_q, state_d;
  logic [SLOT_COUNT-1:0] active_q, active_d;
  logic [SLOT_W-1:0] idx_q, idx_d;

  logic              pend_valid_q, pend_valid_d;
  logic [SLOT_W-1:0] pend_slot_q, pend_slot_d;
  logic [TAG_W-1:0]  pend_tag_q, pend_tag_d;

  logic              out_valid_q, out_valid_d;
  kind_e             kind_q, kind_d;
  logic [SID_W-1:0]  slot_q, slot_d;
  logic [TAG_W-1:0]  tag_q, tag_d;
  logic              last_q, last_d;

  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  entry_t            ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t            rd_entry;

  logic              out_free, in_accept;
  logic              free_found;
  logic [SLOT_W-1:0] free_idx;
  logic [COUNT_W-1:0] dec_count;
  logic              expire;

  mct_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(SLOT_COUNT)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(idx_q),
    .rdata_o(ram_rdata)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign rd_entry  = entry_t'(ram_rdata);
  assign dec_count = rd_entry.count - COUNT_W'(1);
  assign expire    = (dec_count == '0);

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!active_q[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    state_d      = state_q;
    active_d     = active_q;
    idx_d        = idx_q;
    pend_valid_d = pend_valid_q;
    pend_slot_d  = pend_slot_q;
    pend_tag_d   = pend_tag_q;
    out_valid_d  = out_valid_q && out_stall_i;
    kind_d       = kind_q;
    slot_d       = slot_q;
    tag_d        = tag_q;
    last_d       = last_q;
    ram_we       = 1'b0;
    ram_waddr    = idx_q;
    ram_wdata    = rd_entry;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          case (func_i)
            FUNC_START: begin
              out_valid_d = 1'b1;
              tag_d       = '0;
              last_d      = 1'b1;
              if (free_found) begin
                ram_we           = 1'b1;
                ram_waddr        = free_idx;
                ram_wdata.count  = count_ticks_i;
                ram_wdata.period = periodic_i ? count_ticks_i : '0;
                ram_wdata.tag    = handler_tag_i;
                active_d[free_idx] = 1'b1;
                kind_d = KIND_STARTED;
                slot_d = SID_W'(free_idx);
              end else begin
                kind_d = KIND_FULL;
                slot_d = '0;
              end
            end
            FUNC_STOP: begin
              out_valid_d = 1'b1;
              tag_d       = '0;
              last_d      = 1'b1;
              if ({1'b0, slot_id_i} >= (SID_W + 1)'(SLOT_COUNT)) begin
                kind_d = KIND_STOP_IGNORED;
                slot_d = '0;
              end else begin
                active_d[slot_id_i[SLOT_W-1:0]] = 1'b0;
                kind_d = KIND_STOPPED;
                slot_d = slot_id_i;
              end
            end
            FUNC_TICK: begin
              idx_d        = '0;
              pend_valid_d = 1'b0;
              state_d      = ST_READ;
            end
            default: begin
              // unused code: dropped without a result
            end
          endcase
        end
      end

      ST_READ: begin
        if (active_q[idx_q]) begin
          state_d = ST_MOD;
        end else if (idx_q == LAST_SLOT) begin
          state_d = ST_END;
        end else begin
          idx_d = idx_q + SLOT_W'(1);
        end
      end

      ST_MOD: begin
        // an earlier expiry goes out first, now known not to be the last one
        if (!expire || !pend_valid_q || out_free) begin
          ram_we          = 1'b1;
          ram_wdata.count = expire ? rd_entry.period : dec_count;
          if (expire) begin
            if (rd_entry.period == '0) begin
              active_d[idx_q] = 1'b0;
            end
            if (pend_valid_q) begin
              out_valid_d = 1'b1;
              kind_d      = KIND_EXPIRED;
              slot_d      = SID_W'(pend_slot_q);
              tag_d       = pend_tag_q;
              last_d      = 1'b0;
            end
            pend_valid_d = 1'b1;
            pend_slot_d  = idx_q;
            pend_tag_d   = rd_entry.tag;
          end
          if (idx_q == LAST_SLOT) begin
            state_d = ST_END;
          end else begin
            idx_d   = idx_q + SLOT_W'(1);
            state_d = ST_READ;
          end
        end
      end

      ST_END: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          last_d       = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
          if (pend_valid_q) begin
            kind_d = KIND_EXPIRED;
            slot_d = SID_W'(pend_slot_q);
            tag_d  = pend_tag_q;
          end else begin
            kind_d = KIND_NO_EXPIRY;
            slot_d = '0;
            tag_d  = '0;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      active_q     <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      active_q     <= active_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    pend_slot_q <= pend_slot_d;
    pend_tag_q  <= pend_tag_d;
    kind_q      <= kind_d;
    slot_q      <= slot_d;
    tag_q       <= tag_d;
    last_q      <= last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign slot_o        = slot_q;
  assign expired_tag_o = tag_q;
  assign last_o        = last_q;

  `ASSERT_IMPLIES(a_pend_idle, state_q == ST_IDLE, !pend_valid_q,
                  "pending expiry left over after tick walk")
  `ASSERT_IMPLIES(a_mod_active, state_q == ST_MOD, active_q[idx_q],
                  "write back of a free slot")
  `ASSERT_IMPLIES(a_no_exp_last, out_valid_q && kind_q == KIND_NO_EXPIRY, last_q,
                  "no expiry result not marked last")

endmodule

FILE: sv/mct_ram.sv
// generic single write port ram with registered read
module mct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: tb/timer_table_checker.sv
// checker for the countdown timer table: tracks slot state and compares each result
module timer_table_checker
  import mct_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_o,
  input  logic [1:0]         func_i,
  input  logic [COUNT_W-1:0] count_ticks_i,
  input  logic               periodic_i,
  input  logic [TAG_W-1:0]   handler_tag_i,
  input  logic [SID_W-1:0]   slot_id_i,
  input  logic               out_valid_o,
  input  logic               out_stall_i,
  input  logic [2:0]         kind_o,
  input  logic [SID_W-1:0]   slot_o,
  input  logic [TAG_W-1:0]   expired_tag_o,
  input  logic               last_o,
  output int                 fail_count_o,
  output int                 owed_count_o
);

  typedef struct packed {
    kind_e              kind;
    logic [SID_W-1:0]   slot;
    logic [TAG_W-1:0]   tag;
    logic               last;
  } timer_result_t;

  logic               armed       [SLOT_COUNT];
  logic [COUNT_W-1:0] remain      [SLOT_COUNT];
  logic [COUNT_W-1:0] reload      [SLOT_COUNT];
  logic [TAG_W-1:0]   slot_tag_q  [SLOT_COUNT];
  timer_result_t      owed_results[$];

  task automatic report_mismatch(input string what, input logic [15:0] want,
                                 input logic [15:0] got);
    $display("%0t mismatch in %s: expected %0d got %0d", $time, what, want, got);
    fail_count_o++;
  endtask

  function automatic void owe_result(kind_e k, int s, logic [TAG_W-1:0] t, logic l);
    timer_result_t r;
    r.kind = k;
    r.slot = SID_W'(s);
    r.tag  = t;
    r.last = l;
    owed_results.push_back(r);
  endfunction

  function automatic void apply_timer_op(logic [1:0] op, logic [COUNT_W-1:0] cnt,
                                         logic per, logic [TAG_W-1:0] tag,
                                         logic [SID_W-1:0] sid);
    int free_slot;
    int expiries;
    free_slot = -1;
    expiries  = 0;
    case (op)
      FUNC_START: begin
        // lowest free slot wins
        for (int s = SLOT_COUNT - 1; s >= 0; s--) if (!armed[s]) free_slot = s;
        if (free_slot < 0) begin
          owe_result(KIND_FULL, 0, '0, 1'b1);
        end else begin
          armed[free_slot]      = 1'b1;
          remain[free_slot]     = cnt;
          reload[free_slot]     = per ? cnt : '0;
          slot_tag_q[free_slot] = tag;
          owe_result(KIND_STARTED, free_slot, '0, 1'b1);
        end
      end
      FUNC_STOP: begin
        if (sid >= SLOT_COUNT) begin
          owe_result(KIND_STOP_IGNORED, 0, '0, 1'b1);
        end else begin
          armed[sid] = 1'b0;
          owe_result(KIND_STOPPED, int'(sid), '0, 1'b1);
        end
      end
      FUNC_TICK: begin
        for (int s = 0; s < SLOT_COUNT; s++) begin
          if (armed[s]) begin
            remain[s] = remain[s] - 1'b1;
            if (remain[s] == '0) begin
              owe_result(KIND_EXPIRED, s, slot_tag_q[s], 1'b0);
              expiries++;
              if (reload[s] != '0) remain[s] = reload[s];
              else armed[s] = 1'b0;
            end
          end
        end
        if (expiries == 0) owe_result(KIND_NO_EXPIRY, 0, '0, 1'b1);
        else owed_results[owed_results.size() - 1].last = 1'b1;
      end
      default: ;  // unused code gives nothing
    endcase
  endfunction

  task automatic check_result();
    timer_result_t want;
    if (owed_results.size() == 0) begin
      report_mismatch("unexpected result kind", '0, 16'(kind_o));
      return;
    end
    want = owed_results.pop_front();
    if (kind_o !== want.kind) report_mismatch("kind", 16'(want.kind), 16'(kind_o));
    if (slot_o !== want.slot) report_mismatch("slot", 16'(want.slot), 16'(slot_o));
    if (expired_tag_o !== want.tag)
      report_mismatch("expired tag", 16'(want.tag), 16'(expired_tag_o));
    if (last_o !== want.last) report_mismatch("last", 16'(want.last), 16'(last_o));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < SLOT_COUNT; s++) armed[s] = 1'b0;
      owed_results.delete();
      owed_count_o <= 0;
    end else begin
      if (in_valid_i === 1'b1 && in_stall_o === 1'b0)
        apply_timer_op(func_i, count_ticks_i, periodic_i, handler_tag_i, slot_id_i);
      if (out_valid_o === 1'b1 && out_stall_i === 1'b0) check_result();
      owed_count_o <= owed_results.size();
    end
  end

endmodule

FILE: tb/testbench.sv
// top of the countdown timer table bench: clock, reset, stimulus, output stall and verdict
module testbench;
  import mct_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int         HOLD_CYCLES = 150;
  localparam int         QUIET_LIMIT = 2000;
  localparam int         RANDOM_OPS  = 243;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               in_valid_i    = 1'b0;
  logic               in_stall_o;
  logic [1:0]         func_i        = FUNC_START;
  logic [COUNT_W-1:0] count_ticks_i = '0;
  logic               periodic_i    = 1'b0;
  logic [TAG_W-1:0]   handler_tag_i = '0;
  logic [SID_W-1:0]   slot_id_i     = '0;
  logic               out_valid_o;
  logic               out_stall_i   = 1'b0;
  logic [2:0]         kind_o;
  logic [SID_W-1:0]   slot_o;
  logic [TAG_W-1:0]   expired_tag_o;
  logic               last_o;

  int   mismatch_count;
  int   owed_count;
  logic calm     = 1'b0;
  logic hold_req = 1'b0;

  multi_slot_countdown_timer_table i_dut (.*);

  timer_table_checker i_checker (
    .fail_count_o (mismatch_count),
    .owed_count_o (owed_count),
    .*
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // offer one transaction, with random idle cycles ahead of it
  task automatic offer(input logic [1:0] op, input logic [COUNT_W-1:0] cnt,
                       input logic per, input logic [TAG_W-1:0] tag,
                       input logic [SID_W-1:0] sid);
    while (!calm && $urandom_range(99) < 19) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    func_i        <= op;
    count_ticks_i <= cnt;
    periodic_i    <= per;
    handler_tag_i <= tag;
    slot_id_i     <= sid;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
  endtask

  // output side stall, including one long hold-off
  initial begin
    int   hold_left;
    logic hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !calm && ($urandom_range(99) < 19);
      end
    end
  end

  // watchdog: too long without any transaction on either channel
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int                 pick;
    logic [1:0]         op;
    logic [COUNT_W-1:0] cnt;
    logic [SID_W-1:0]   sid;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    offer(FUNC_TICK, '0, 1'b0, '0, '0);             // tick on an empty table
    offer(FUNC_START, 16'd1, 1'b0, 8'hFF, '0);
    offer(FUNC_START, 16'd1, 1'b1, 8'h00, '0);
    offer(FUNC_START, 16'd1, 1'b0, 8'h11, '0);
    offer(FUNC_START, 16'd1, 1'b1, 8'h22, '0);
    offer(FUNC_START, 16'd1, 1'b0, 8'h44, '0);
    offer(FUNC_START, 16'd1, 1'b0, 8'h88, '0);
    offer(FUNC_START, 16'd1, 1'b1, 8'hA5, '0);
    offer(FUNC_START, 16'd1, 1'b0, 8'h5A, '0);
    offer(FUNC_START, 16'd3, 1'b0, 8'h77, '0);      // table full
    offer(FUNC_TICK, '0, 1'b0, '0, '0);             // every slot expires
    offer(FUNC_START, 16'd0, 1'b1, 8'hC3, '0);      // zero count wraps, no reload
    offer(FUNC_START, 16'hFFFF, 1'b0, 8'h3C, '0);
    offer(FUNC_TICK, '0, 1'b0, '0, '0);
    offer(FUNC_STOP, '0, 1'b0, '0, 4'd15);          // out of range
    offer(FUNC_STOP, '0, 1'b0, '0, 4'd8);
    offer(FUNC_STOP, '0, 1'b0, '0, 4'd6);           // stop of an active periodic slot
    offer(FUNC_UNUSED, 16'hFFFF, 1'b1, 8'hFF, 4'hF);
    for (int s = 0; s < SLOT_COUNT; s++) offer(FUNC_STOP, '0, 1'b0, '0, SID_W'(s));
    offer(FUNC_TICK, '0, 1'b0, '0, '0);

    // random part: mostly short counts so slots keep expiring
    for (int n = 0; n < RANDOM_OPS; n++) begin
      calm <= (n >= 60 && n < 120);
      if (n == 150) hold_req <= 1'b1;
      pick = $urandom_range(99);
      if (pick < 45) op = FUNC_TICK;
      else if (pick < 72) op = FUNC_START;
      else if (pick < 94) op = FUNC_STOP;
      else op = FUNC_UNUSED;
      pick = $urandom_range(99);
      if (pick < 80) cnt = COUNT_W'($urandom_range(1, 8));
      else if (pick < 85) cnt = '0;
      else cnt = COUNT_W'($urandom_range(65535));
      sid = ($urandom_range(99) < 80) ? SID_W'($urandom_range(0, SLOT_COUNT - 1))
                                      : SID_W'($urandom_range(SLOT_COUNT, 15));
      offer(op, cnt, 1'($urandom_range(1)), TAG_W'($urandom_range(255)), sid);
    end

    in_valid_i <= 1'b0;
    calm       <= 1'b0;
    @(posedge clk_i);
    while (owed_count != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0 && owed_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
